// ===== src/mvre_pkg.sv =====
`timescale 1ns / 1ps

package mvre_pkg;

	localparam int WORD_W = 32;
	localparam int LEN_W = 26;
	// widest run the float conversion handles: 2^24 needs 25 bits
	localparam int RUN_MAX_W = 25;
	localparam int CFG_IDX_W = 1;
	localparam int BURST_MAX = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_MISSING_VALUE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 1'b1;

	localparam logic [WORD_W-1:0] MISSING_RESET = 32'h0000_0000;
	localparam logic [LEN_W-1:0] CAPACITY_RESET = 26'd33554432;

	typedef enum logic [1:0] {
		KIND_VALUE = 2'd0,
		KIND_MARKER = 2'd1,
		KIND_RUN = 2'd2
	} kind_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_word;
		kind_t word_kind;
		logic status;
		logic [LEN_W-1:0] encoded_length;
		logic out_last;
	} result_t;

	function automatic logic is_nan(input logic [WORD_W-1:0] w);
		return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
	endfunction

	// IEEE equality: +0 == -0, NaN equals nothing
	function automatic logic ieee_equal(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic res;
		if (is_nan(a) || is_nan(b)) begin
			res = 1'b0;
		end else if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
			res = 1'b1;
		end else begin
			res = (a == b);
		end
		return res;
	endfunction

	// exact single for 1..2^24
	function automatic logic [WORD_W-1:0] count_to_single(input logic [RUN_MAX_W-1:0] n);
		logic [4:0] p;
		logic [47:0] sh;
		logic [22:0] mant;
		logic [7:0] expo;
		logic [WORD_W-1:0] res;
		p = 5'd0;
		for (int i = 0; i < RUN_MAX_W; i++) begin
			if (n[i]) begin
				p = 5'(i);
			end
		end
		sh = 48'(n) << (5'd23 - p);
		if (p > 5'd23) begin
			mant = 23'd0;
		end else begin
			mant = sh[22:0];
		end
		expo = 8'd127 + 8'(p);
		if (n == '0) begin
			res = '0;
		end else begin
			res = {1'b0, expo, mant};
		end
		return res;
	endfunction

endpackage

// ===== src/mvre_if.sv =====
`timescale 1ns / 1ps

interface mvre_in_if;
	import mvre_pkg::*;

	logic valid;
	logic ready;
	logic [WORD_W-1:0] sample_word;
	logic field_last;

	modport source (output valid, output sample_word, output field_last, input ready);
	modport sink (input valid, input sample_word, input field_last, output ready);
endinterface

interface mvre_out_if;
	import mvre_pkg::*;

	logic valid;
	logic ready;
	logic [WORD_W-1:0] out_word;
	kind_t word_kind;
	logic status;
	logic [LEN_W-1:0] encoded_length;
	logic out_last;

	modport source (output valid, output out_word, output word_kind, output status,
		output encoded_length, output out_last, input ready);
	modport sink (input valid, input out_word, input word_kind, input status,
		input encoded_length, input out_last, output ready);
endinterface

// ===== src/mvre_out_buf.sv =====
`timescale 1ns / 1ps

module mvre_out_buf (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic [1:0] load_cnt,
	input mvre_pkg::result_t load_ent [mvre_pkg::BURST_MAX],
	output logic free,
	mvre_out_if.source encoded
);
	import mvre_pkg::*;

	result_t ent_q [BURST_MAX];
	logic [1:0] head_q;
	logic [1:0] rem_q;
	logic fire;
	result_t cur;

	assign fire = encoded.valid && encoded.ready;
	// free once the last held result leaves this cycle
	assign free = (rem_q == 2'd0) || ((rem_q == 2'd1) && encoded.ready);

	always_comb begin
		cur = ent_q[head_q];
	end

	assign encoded.valid = (rem_q != 2'd0);
	assign encoded.out_word = cur.out_word;
	assign encoded.word_kind = cur.word_kind;
	assign encoded.status = cur.status;
	assign encoded.encoded_length = cur.encoded_length;
	assign encoded.out_last = cur.out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			head_q <= 2'd0;
		end else if (load) begin
			rem_q <= load_cnt;
			head_q <= 2'd0;
		end else if (fire) begin
			rem_q <= rem_q - 2'd1;
			head_q <= head_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_ent;
		end
	end

endmodule

// ===== src/missing_value_run_encoder.sv =====
`timescale 1ns / 1ps

// channel   dir  payload                                             handshake
// samples   in   sample_word[31:0], field_last                        valid/ready
// encoded   out  out_word[31:0], word_kind[1:0], status,              valid/ready
//                encoded_length[25:0], out_last
// cfg_*     in   cfg_idx[0], cfg_wdata[31:0]                          cfg_we
//
// One request per cycle while each yields at most one result and encoded is ready;
// a request that flushes a run yields up to three results and holds the input stage
// until the output burst buffer drains (one result a cycle while encoded is ready).
// A request's first result passes the input register and then the burst buffer.
// arst_n clears the run, word count, drop flag and both buffers; registers
// return to missing value +0.0 and capacity 2^25.

module missing_value_run_encoder #(
	parameter int MAX_FIELD_LEN = 16777216
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mvre_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [mvre_pkg::WORD_W-1:0] cfg_wdata,
	mvre_in_if.sink samples,
	mvre_out_if.source encoded
);
	import mvre_pkg::*;

	localparam int RUN_W = $clog2(MAX_FIELD_LEN + 1);
	localparam logic [RUN_W-1:0] RUN_SAT = RUN_W'(MAX_FIELD_LEN);

	logic [WORD_W-1:0] missing_value_q;
	logic [LEN_W-1:0] out_capacity_q;

	logic valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic last_s1;

	logic [RUN_W-1:0] run_length_q;
	logic [LEN_W-1:0] words_written_q;
	logic overflow_drop_q;

	logic buf_free;
	logic adv;
	logic [1:0] n_res;
	result_t ent [BURST_MAX];

	logic missing;
	logic [RUN_W-1:0] run_inc;
	logic [RUN_W-1:0] run_used;
	logic [1:0] need;
	logic [LEN_W:0] need_sum;
	logic over;
	logic [WORD_W-1:0] run_flt;
	logic [RUN_W-1:0] run_d;
	logic [LEN_W-1:0] ww_d;
	logic drop_d;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missing_value_q <= MISSING_RESET;
			out_capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MISSING_VALUE: missing_value_q <= cfg_wdata;
				CFG_OUT_CAPACITY: out_capacity_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign samples.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			word_s1 <= samples.sample_word;
			last_s1 <= samples.field_last;
		end
	end

	always_comb begin
		missing = ieee_equal(word_s1, missing_value_q);
		run_inc = (run_length_q < RUN_SAT) ? run_length_q + RUN_W'(1) : run_length_q;
		run_used = missing ? run_inc : run_length_q;
		if (missing) begin
			need = 2'd2;
		end else if (run_length_q != '0) begin
			need = 2'd3;
		end else begin
			need = 2'd1;
		end
		need_sum = {1'b0, words_written_q} + (LEN_W+1)'(need);
		over = need_sum > {1'b0, out_capacity_q};
		run_flt = count_to_single(RUN_MAX_W'(run_used));

		n_res = 2'd0;
		run_d = run_length_q;
		ww_d = words_written_q;
		drop_d = overflow_drop_q;
		for (int i = 0; i < BURST_MAX; i++) begin
			ent[i] = '{out_word: '0, word_kind: KIND_VALUE, status: 1'b0,
				encoded_length: '0, out_last: 1'b0};
		end

		if (overflow_drop_q) begin
			n_res = 2'd0;
		end else if (missing && !last_s1) begin
			run_d = run_inc;
		end else if (over) begin
			n_res = 2'd1;
			ent[0] = '{out_word: '0, word_kind: KIND_VALUE, status: 1'b1,
				encoded_length: words_written_q, out_last: 1'b1};
			run_d = run_used;
			drop_d = 1'b1;
		end else if (run_used != '0) begin
			ent[0] = '{out_word: missing_value_q, word_kind: KIND_MARKER, status: 1'b0,
				encoded_length: words_written_q + LEN_W'(1), out_last: 1'b0};
			ent[1] = '{out_word: run_flt, word_kind: KIND_RUN, status: 1'b0,
				encoded_length: words_written_q + LEN_W'(2), out_last: missing};
			ent[2] = '{out_word: word_s1, word_kind: KIND_VALUE, status: 1'b0,
				encoded_length: words_written_q + LEN_W'(3), out_last: last_s1};
			n_res = missing ? 2'd2 : 2'd3;
			ww_d = words_written_q + LEN_W'(n_res);
			run_d = '0;
		end else begin
			ent[0] = '{out_word: word_s1, word_kind: KIND_VALUE, status: 1'b0,
				encoded_length: words_written_q + LEN_W'(1), out_last: last_s1};
			n_res = 2'd1;
			ww_d = words_written_q + LEN_W'(1);
		end

		if (last_s1) begin
			run_d = '0;
			ww_d = '0;
			drop_d = 1'b0;
		end
	end

	assign adv = valid_s1 && ((n_res == 2'd0) || buf_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= '0;
			words_written_q <= '0;
			overflow_drop_q <= 1'b0;
		end else if (adv) begin
			run_length_q <= run_d;
			words_written_q <= ww_d;
			overflow_drop_q <= drop_d;
		end
	end

	mvre_out_buf u_out_buf (
		.clk (clk),
		.arst_n (arst_n),
		.load (adv && (n_res != 2'd0)),
		.load_cnt (n_res),
		.load_ent (ent),
		.free (buf_free),
		.encoded (encoded)
	);

	a_field_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> (run_length_q == '0) && (words_written_q == '0)
			&& !overflow_drop_q)
		else $error("field state not cleared after last request");

	a_run_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		run_length_q <= RUN_SAT)
		else $error("run length beyond saturation");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		encoded.valid && encoded.status |-> encoded.out_last
			&& (encoded.word_kind == KIND_VALUE))
		else $error("overflow result not marked last");

	a_drop_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_drop_q && $past(overflow_drop_q) && !encoded.valid |=> !encoded.valid)
		else $error("output produced while dropping field");

endmodule

// ===== verif/missing_value_run_encoder_test.sv =====
`timescale 1ns / 1ps

module missing_value_run_encoder_test;
	import mvre_pkg::*;

	localparam int RANDOM_ITEMS = 330;
	localparam int STEADY_AFTER = 280;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RUN_CAP = 16777216;
	localparam logic [LEN_W-1:0] CAP_MAX = 26'd33554432;
	localparam logic ST_OK = 1'b0;
	localparam logic ST_OVERFLOW = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic last;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_MISSING_VALUE;
	logic [WORD_W-1:0] cfg_wdata = '0;

	mvre_in_if samples_if();
	mvre_out_if encoded_if();

	missing_value_run_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.samples(samples_if),
		.encoded(encoded_if)
	);

	// register shadows and encoder state
	logic [WORD_W-1:0] miss_val = MISSING_RESET;
	logic [LEN_W-1:0] capacity = CAPACITY_RESET;
	logic [RUN_MAX_W-1:0] run_len = '0;
	logic [LEN_W-1:0] words_out = '0;
	logic dropping = 1'b0;

	sample_t sample_q[$];
	result_t encoded_q[$];

	int queued_items = 0;
	int errors = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;
	int gap_pct = 0;
	int stall_pct = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit took_sample = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit is_nan_word(input logic [WORD_W-1:0] w);
		return (&w[30:23]) && (|w[22:0]);
	endfunction

	function automatic bit float_eq(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		if (is_nan_word(a) || is_nan_word(b)) begin
			return 1'b0;
		end
		if (a[30:0] == '0 && b[30:0] == '0) begin
			return 1'b1;
		end
		return a == b;
	endfunction

	// exact for counts up to 2^24
	function automatic logic [WORD_W-1:0] run_to_float(input logic [RUN_MAX_W-1:0] n);
		int msb;
		bit found;
		logic [47:0] frac;
		msb = 0;
		found = 1'b0;
		for (int i = RUN_MAX_W - 1; i >= 0; i--) begin
			if (!found && n[i]) begin
				msb = i;
				found = 1'b1;
			end
		end
		frac = (48'(n) << 23) >> msb;
		if (n == '0) begin
			return '0;
		end
		return {1'b0, 8'(127 + msb), frac[22:0]};
	endfunction

	function automatic logic [WORD_W-1:0] nan_pattern();
		return {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
	endfunction

	function automatic result_t make_result(input logic [WORD_W-1:0] w, input kind_t k,
			input logic st, input logic [LEN_W-1:0] n, input logic l);
		result_t r;
		r.out_word = w;
		r.word_kind = k;
		r.status = st;
		r.encoded_length = n;
		r.out_last = l;
		return r;
	endfunction

	task automatic clear_field();
		run_len = '0;
		words_out = '0;
		dropping = 1'b0;
	endtask

	task automatic encode_sample(input sample_t s);
		bit is_miss;
		int need;
		if (dropping) begin
			if (s.last) begin
				clear_field();
			end
			return;
		end
		is_miss = float_eq(s.word, miss_val);
		if (is_miss) begin
			if (run_len < RUN_CAP) begin
				run_len++;
			end
			if (!s.last) begin
				return;
			end
			need = 2;
		end else begin
			need = (run_len != '0) ? 3 : 1;
		end
		if (int'(words_out) + need > int'(capacity)) begin
			encoded_q.push_back(make_result('0, KIND_VALUE, ST_OVERFLOW, words_out, 1'b1));
			if (s.last) begin
				clear_field();
			end else begin
				dropping = 1'b1;
			end
			return;
		end
		if (run_len != '0) begin
			words_out++;
			encoded_q.push_back(make_result(miss_val, KIND_MARKER, ST_OK, words_out, 1'b0));
			words_out++;
			encoded_q.push_back(make_result(run_to_float(run_len), KIND_RUN, ST_OK, words_out,
				is_miss && s.last));
			run_len = '0;
		end
		if (!is_miss) begin
			words_out++;
			encoded_q.push_back(make_result(s.word, KIND_VALUE, ST_OK, words_out, s.last));
		end
		if (s.last) begin
			clear_field();
		end
	endtask

	// accept requests into the predictor, check encoded words
	always @(posedge clk) begin : sample_side
		result_t want;
		result_t got;
		took_sample = arst_n && samples_if.valid && samples_if.ready;
		if (took_sample) begin
			encode_sample(sample_q.pop_front());
		end
		if (arst_n && encoded_if.valid && encoded_if.ready) begin
			got = make_result(encoded_if.out_word, encoded_if.word_kind, encoded_if.status,
				encoded_if.encoded_length, encoded_if.out_last);
			if (encoded_q.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: unexpected result: word %h kind %0d status %0b length %0d last %0b",
						$realtime, got.out_word, got.word_kind, got.status,
						got.encoded_length, got.out_last);
				end
			end else begin
				want = encoded_q.pop_front();
				if (got.out_word !== want.out_word || got.word_kind !== want.word_kind ||
						got.status !== want.status ||
						got.encoded_length !== want.encoded_length ||
						got.out_last !== want.out_last) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: mismatch: expected word %h kind %0d status %0b length %0d last %0b",
							$realtime, want.out_word, want.word_kind, want.status,
							want.encoded_length, want.out_last);
						$display("%0t:           got word %h kind %0d status %0b length %0d last %0b",
							$realtime, got.out_word, got.word_kind, got.status,
							got.encoded_length, got.out_last);
					end
				end
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
		end else if (!(samples_if.valid && !took_sample)) begin
			if (gap_left > 0) begin
				gap_left--;
				samples_if.valid <= 1'b0;
			end else if (!steady && $urandom_range(99) < gap_pct) begin
				gap_left = $urandom_range(15);
				samples_if.valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				samples_if.valid <= 1'b1;
				samples_if.sample_word <= sample_q[0].word;
				samples_if.field_last <= sample_q[0].last;
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			encoded_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			encoded_if.ready <= 1'b0;
		end else if (!steady && $urandom_range(99) < stall_pct) begin
			stall_left = $urandom_range(15);
			encoded_if.ready <= 1'b0;
		end else begin
			encoded_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (samples_if.valid && samples_if.ready) ||
				(encoded_if.valid && encoded_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_sample(input logic [WORD_W-1:0] w, input logic l);
		sample_q.push_back('{word: w, last: l});
		queued_items++;
	endtask

	// drained, plus a settling wait for requests that make no result
	task automatic settle();
		while (sample_q.size() != 0 || encoded_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_regs(input bit set_mv, input logic [WORD_W-1:0] mv,
			input bit set_cap, input logic [LEN_W-1:0] cap);
		settle();
		if (set_mv) begin
			cfg_we <= 1'b1;
			cfg_idx <= CFG_MISSING_VALUE;
			cfg_wdata <= mv;
			miss_val = mv;
			@(negedge clk);
		end
		if (set_cap) begin
			cfg_we <= 1'b1;
			cfg_idx <= CFG_OUT_CAPACITY;
			cfg_wdata <= WORD_W'(cap);
			capacity = cap;
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] pick_word(input int miss_pct);
		int r;
		logic [WORD_W-1:0] w;
		r = $urandom_range(99);
		if (r < miss_pct) begin
			w = miss_val;
		end else if (r < miss_pct + 8) begin
			w = {1'($urandom_range(1)), 31'd0};
		end else if (r < miss_pct + 14) begin
			w = nan_pattern();
		end else if (r < miss_pct + 20) begin
			case ($urandom_range(5))
				0: w = 32'hFFFF_FFFF;
				1: w = 32'h7F80_0000;
				2: w = 32'hFF80_0000;
				3: w = 32'h0000_0001;
				4: w = miss_val ^ 32'h8000_0000;
				default: w = miss_val ^ 32'h0000_0001;
			endcase
		end else begin
			w = $urandom;
		end
		return w;
	endfunction

	task automatic random_phase();
		logic [WORD_W-1:0] mv;
		logic [LEN_W-1:0] cap;
		int pick;
		int miss_pct;
		int target;
		int n;
		int len;
		case ($urandom_range(7))
			0: mv = 32'h0000_0000;
			1: mv = 32'h8000_0000;
			2: mv = nan_pattern();
			3: mv = $urandom_range(1) ? 32'h7F80_0000 : 32'hFF80_0000;
			4: mv = 32'hFFFF_FFFF;
			default: mv = $urandom;
		endcase
		case ($urandom_range(7))
			0: cap = LEN_W'($urandom_range(1));
			1: cap = LEN_W'($urandom_range(2, 3));
			2, 3, 4: cap = LEN_W'($urandom_range(4, 24));
			5: cap = CAP_MAX;
			6: cap = LEN_W'($urandom_range(200, 33554432));
			default: cap = LEN_W'($urandom_range(25, 200));
		endcase
		pick = $urandom_range(2);
		program_regs(pick != 2, mv, pick != 1, cap);
		case ($urandom_range(2))
			0: gap_pct = 0;
			1: gap_pct = 10;
			default: gap_pct = 40;
		endcase
		case ($urandom_range(2))
			0: stall_pct = 0;
			1: stall_pct = 10;
			default: stall_pct = 40;
		endcase
		miss_pct = $urandom_range(10, 80);
		target = $urandom_range(20, 40);
		n = 0;
		while (n < target) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				queue_sample(pick_word(miss_pct), i == len - 1);
			end
			n += len;
		end
		// sometimes leave a field open across the next register write
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 5)) queue_sample(pick_word(miss_pct), 1'b0);
		end
	endtask

	initial begin
		samples_if.valid = 1'b0;
		samples_if.sample_word = '0;
		samples_if.field_last = 1'b0;
		encoded_if.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		gap_pct = 20;
		stall_pct = 20;

		// plain values, +0/-0 runs, NaN never missing, flush at field end
		program_regs(1'b1, 32'h0000_0000, 1'b1, CAP_MAX);
		queue_sample(32'h3F80_0000, 1'b0);
		queue_sample(32'h0000_0000, 1'b0);
		queue_sample(32'h8000_0000, 1'b0);
		queue_sample(32'h7FC0_0000, 1'b0);
		queue_sample(32'hFFFF_FFFF, 1'b1);
		queue_sample(32'h0000_0000, 1'b0);
		queue_sample(32'h0000_0000, 1'b1);
		queue_sample(32'h8000_0000, 1'b1);

		// NaN marker: no runs; overflow then drop to field end
		program_regs(1'b1, 32'h7FC0_0000, 1'b1, 26'd2);
		queue_sample(32'h7FC0_0000, 1'b0);
		queue_sample(32'h0000_0000, 1'b0);
		queue_sample(32'h7FC0_0000, 1'b0);
		queue_sample(32'h1234_5678, 1'b1);

		// overflow on the final flush, then overflow on a run flush
		program_regs(1'b1, 32'hC2C8_0000, 1'b0, '0);
		queue_sample(32'h3F80_0000, 1'b0);
		queue_sample(32'hC2C8_0000, 1'b1);
		queue_sample(32'hC2C8_0000, 1'b0);
		queue_sample(32'h4000_0000, 1'b0);
		queue_sample(32'hC2C8_0000, 1'b1);

		// zero capacity, -0 marker matching +0
		program_regs(1'b1, 32'h8000_0000, 1'b1, '0);
		queue_sample(32'h0000_0000, 1'b1);
		queue_sample(32'h0000_0001, 1'b1);

		program_regs(1'b1, 32'h7F80_0000, 1'b1, CAP_MAX);
		queue_sample(32'h7F80_0000, 1'b0);
		queue_sample(32'h7F80_0000, 1'b0);
		queue_sample(32'h7F80_0000, 1'b0);
		queue_sample(32'hFF80_0000, 1'b1);

		program_regs(1'b1, 32'hFFFF_FFFF, 1'b0, '0);
		queue_sample(32'hFFFF_FFFF, 1'b1);

		while (queued_items < RANDOM_ITEMS) begin
			steady = (queued_items >= STEADY_AFTER);
			random_phase();
		end
		settle();

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/mvre_pkg.sv
src/mvre_if.sv
src/mvre_out_buf.sv
src/missing_value_run_encoder.sv
verif/missing_value_run_encoder_test.sv
